// File: rtl/i2cscfc_pkg.sv
// Package for the I2C slave command frame checksum block: action codes, frame positions, result type.
package i2cscfc_pkg;

	// Action codes carried by each input item
	localparam logic [1:0] ACT_RX_BYTE = 2'd0;
	localparam logic [1:0] ACT_TX_REQ  = 2'd1;
	localparam logic [1:0] ACT_STOP    = 2'd2;

	// Byte positions inside a command frame (count after increment)
	localparam logic [7:0] POS_ADDR     = 8'd1;
	localparam logic [7:0] POS_COMMAND  = 8'd2;
	localparam logic [7:0] POS_DATA     = 8'd3;
	localparam logic [7:0] POS_CHECKSUM = 8'd4;

	// Bytes held in the readback word
	localparam int unsigned TX_WORD_BYTES = 4;

	// One result item
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       event_valid;
		logic [7:0] event_command;
		logic [7:0] event_data;
		logic       int_ack;
	} result_t;

endpackage

// File: rtl/i2c_slave_command_frame_checksum.sv
// Top level of the I2C slave command frame checksum block.
// Frames 4-byte writes (address, command, data, checksum) and answers reads with the
// checksum or, after a passing interrupt request, with bytes of tx_buffer_word.
// One item is accepted per clock cycle while the result side keeps taking results. An
// item is registered on entry, then the frame state and the result register are updated
// together once the result register can take a result, and the result is offered from
// the result register. The update of the frame state for each item is what sets the
// rate. The result register is independent of the input register, so an item can be
// taken into an empty input register while a result still waits.
// The configuration register may be written only while the block is idle.
module i2c_slave_command_frame_checksum
	import i2cscfc_pkg::*;
#(
	parameter int unsigned REPLY_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] tx_buffer_word,
	// result item channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        event_valid,
	output logic [7:0]  event_command,
	output logic [7:0]  event_data,
	output logic        int_ack
);

	// Readback limit saturates at the width of the send counter
	localparam logic [2:0] READ_LIMIT = (REPLY_BYTES > 7) ? 3'd7 : 3'(REPLY_BYTES);

	// Configuration register
	logic [7:0] int_request_command_q;

	// Input stage
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [7:0]  rx_byte_s1;
	logic [31:0] tx_word_s1;

	// Frame state
	logic [7:0] receive_count_q;
	logic [2:0] send_count_q;
	logic [2:0] send_limit_q;
	logic [7:0] checksum_q;
	logic [7:0] command_q;
	logic [7:0] data_q;

	// Next frame state and result
	logic [7:0] receive_count_n;
	logic [2:0] send_count_n;
	logic [2:0] send_limit_n;
	logic [7:0] checksum_n;
	logic [7:0] command_n;
	logic [7:0] data_n;
	logic [7:0] count_inc;
	logic [7:0] sum_data;
	logic       is_int_cmd;
	result_t    res_n;

	// Result register
	logic    out_valid_q;
	result_t res_q;

	logic advance;

	// Handshakes: the input stage moves on whenever the result register can take a result
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_request_command_q <= '0;
		end else if (cfg_valid) begin
			int_request_command_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1  <= action;
			rx_byte_s1 <= rx_byte;
			tx_word_s1 <= tx_buffer_word;
		end
	end

	assign count_inc  = receive_count_q + 8'd1;
	assign sum_data   = checksum_q + rx_byte_s1;
	assign is_int_cmd = (command_q == int_request_command_q);

	// Frame logic for one item
	always_comb begin
		receive_count_n = receive_count_q;
		send_count_n    = send_count_q;
		send_limit_n    = send_limit_q;
		checksum_n      = checksum_q;
		command_n       = command_q;
		data_n          = data_q;
		res_n           = '0;
		unique case (action_s1)
			ACT_RX_BYTE: begin
				receive_count_n = count_inc;
				unique case (count_inc)
					POS_ADDR: begin
						checksum_n = '0;
					end
					POS_COMMAND: begin
						command_n  = rx_byte_s1;
						checksum_n = sum_data;
					end
					POS_DATA: begin
						if (is_int_cmd) begin
							// interrupt request: third byte is the complemented command sum
							if (~checksum_q == rx_byte_s1) begin
								send_limit_n  = READ_LIMIT;
								res_n.int_ack = 1'b1;
							end
						end else begin
							data_n     = rx_byte_s1;
							checksum_n = ~sum_data;
						end
					end
					POS_CHECKSUM: begin
						if (checksum_q == rx_byte_s1) begin
							res_n.event_valid   = 1'b1;
							res_n.event_command = command_q;
							res_n.event_data    = data_q;
						end else begin
							// bad checksum: reply with the plain sum
							checksum_n = ~checksum_q;
						end
						send_count_n    = '0;
						receive_count_n = '0;
						send_limit_n    = 3'd1;
					end
					default: begin
					end
				endcase
			end
			ACT_TX_REQ: begin
				if (send_count_q != send_limit_q) begin
					send_count_n   = send_count_q + 3'd1;
					res_n.tx_valid = 1'b1;
					if (is_int_cmd) begin
						// readback byte index is the count before the increment
						if (32'(send_count_q) < TX_WORD_BYTES) begin
							res_n.tx_byte = tx_word_s1[{send_count_q[1:0], 3'b000} +: 8];
						end
					end else begin
						res_n.tx_byte = checksum_q;
						checksum_n    = '0;
					end
				end
			end
			ACT_STOP: begin
				receive_count_n = '0;
				send_count_n    = '0;
			end
			default: begin
			end
		endcase
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receive_count_q <= '0;
			send_count_q    <= '0;
			send_limit_q    <= '0;
			checksum_q      <= '0;
			command_q       <= '0;
			data_q          <= '0;
		end else if (advance) begin
			receive_count_q <= receive_count_n;
			send_count_q    <= send_count_n;
			send_limit_q    <= send_limit_n;
			checksum_q      <= checksum_n;
			command_q       <= command_n;
			data_q          <= data_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_valid      = res_q.tx_valid;
	assign tx_byte       = res_q.tx_byte;
	assign event_valid   = res_q.event_valid;
	assign event_command = res_q.event_command;
	assign event_data    = res_q.event_data;
	assign int_ack       = res_q.int_ack;

	// Reads never run past the armed limit
	a_send_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		send_count_q <= send_limit_q)
		else $error("send count above send limit");

	// A result carries at most one kind of outcome
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones({res_q.tx_valid, res_q.event_valid, res_q.int_ack}) <= 1)
		else $error("result carries more than one outcome");

	// A stop leaves both counters cleared
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_s1 == ACT_STOP) |=> (receive_count_q == '0 && send_count_q == '0))
		else $error("stop did not clear counters");

	// Input stalls only behind a held item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a held item");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the I2C slave command frame checksum block.
module tb
	import i2cscfc_pkg::*;
();

	localparam int unsigned REPLY_BYTES = 4;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [2:0] SINGLE_REPLY = 3'd1;
	localparam logic [2:0] READBACK_LIMIT = (REPLY_BYTES > 7) ? 3'd7 : 3'(REPLY_BYTES);
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 200;
	localparam int MAX_REPORTS = 40;

	// Frame predictor and queue of results still due from the block
	class frame_scoreboard;
		logic [7:0] irq_cmd;
		logic [7:0] rx_count;
		logic [2:0] tx_count;
		logic [2:0] tx_limit;
		logic [7:0] sum_reg;
		logic [7:0] cmd_hold;
		logic [7:0] data_hold;
		result_t due_results[$];
		int errors;

		function new();
			irq_cmd = '0;
			rx_count = '0;
			tx_count = '0;
			tx_limit = '0;
			sum_reg = '0;
			cmd_hold = '0;
			data_hold = '0;
			errors = 0;
		endfunction

		function void set_command(logic [7:0] value);
			irq_cmd = value;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		// Advance the frame state by one accepted item and queue its result
		function void note_item(logic [1:0] act, logic [7:0] b, logic [31:0] w);
			result_t r;
			logic [7:0] inv_sum;
			logic [2:0] idx;
			r = '0;
			case (act)
				ACT_RX_BYTE: begin
					rx_count = rx_count + 8'd1;
					case (rx_count)
						POS_ADDR: sum_reg = '0;
						POS_COMMAND: begin
							cmd_hold = b;
							sum_reg = sum_reg + b;
						end
						POS_DATA: begin
							if (cmd_hold == irq_cmd) begin
								// interrupt request: data byte must be the inverted command sum
								inv_sum = ~sum_reg;
								if (inv_sum == b) begin
									tx_limit = READBACK_LIMIT;
									r.int_ack = 1'b1;
								end
							end else begin
								data_hold = b;
								sum_reg = ~(sum_reg + b);
							end
						end
						POS_CHECKSUM: begin
							if (sum_reg == b) begin
								r.event_valid = 1'b1;
								r.event_command = cmd_hold;
								r.event_data = data_hold;
							end else begin
								// bad checksum: reply carries the plain sum
								sum_reg = ~sum_reg;
							end
							tx_count = '0;
							rx_count = '0;
							tx_limit = SINGLE_REPLY;
						end
						default: ;
					endcase
				end
				ACT_TX_REQ: begin
					if (tx_count != tx_limit) begin
						tx_count = tx_count + 3'd1;
						r.tx_valid = 1'b1;
						if (cmd_hold == irq_cmd) begin
							idx = tx_count - 3'd1;
							r.tx_byte = (idx < TX_WORD_BYTES) ? w[8*idx +: 8] : 8'h00;
						end else begin
							r.tx_byte = sum_reg;
							sum_reg = '0;
						end
					end
				end
				ACT_STOP: begin
					rx_count = '0;
					tx_count = '0;
				end
				default: ;
			endcase
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result item with none expected, expected none actual %h",
						$time, got);
				return;
			end
			want = due_results.pop_front();
			compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
			compare_field("tx_byte", want.tx_byte, got.tx_byte);
			compare_field("event_valid", 8'(want.event_valid), 8'(got.event_valid));
			compare_field("event_command", want.event_command, got.event_command);
			compare_field("event_data", want.event_data, got.event_data);
			compare_field("int_ack", 8'(want.int_ack), 8'(got.int_ack));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [7:0]  rx_byte;
	logic [31:0] tx_buffer_word;
	logic        out_valid;
	logic        out_ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        event_valid;
	logic [7:0]  event_command;
	logic [7:0]  event_data;
	logic        int_ack;

	frame_scoreboard sb;
	int counted = 0;
	int cycle_count = 0;
	bit send_idle;
	int stall_pct;
	bit long_hold;

	i2c_slave_command_frame_checksum #(
		.REPLY_BYTES(REPLY_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.rx_byte(rx_byte),
		.tx_buffer_word(tx_buffer_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.event_valid(event_valid),
		.event_command(event_command),
		.event_data(event_data),
		.int_ack(int_ack)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("i2c_slave_command_frame_checksum verification failed");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	// Check every result item the block hands over
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{tx_valid, tx_byte, event_valid, event_command, event_data, int_ack});
	end

	// Result side backpressure, with an occasional long hold-off
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				n = idle_len();
				repeat (n) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one item and wait until the block takes it
	task automatic drive_item(input logic [1:0] act, input logic [7:0] b, input logic [31:0] w);
		int gap;
		gap = send_idle ? idle_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= b;
		tx_buffer_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(act, b, w);
		if (act != ACT_UNUSED)
			counted++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		drive_item(ACT_RX_BYTE, b, $urandom());
	endtask

	task automatic send_read(input logic [31:0] w);
		drive_item(ACT_TX_REQ, 8'($urandom_range(0, 255)), w);
	endtask

	task automatic send_stop();
		drive_item(ACT_STOP, 8'($urandom_range(0, 255)), $urandom());
	endtask

	// Stop offering and wait for every result still due
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_command(input logic [7:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_command(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Address, command, data, checksum; checksum mostly right
	task automatic random_frame();
		logic [7:0] cmd;
		logic [7:0] data;
		logic [7:0] sum;
		cmd = ($urandom_range(0, 4) == 0) ? sb.irq_cmd : 8'($urandom_range(0, 255));
		data = 8'($urandom_range(0, 255));
		sum = ~(cmd + data);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(cmd);
		send_byte(data);
		send_byte(($urandom_range(0, 3) != 0) ? sum : 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 2)) send_read($urandom());
	endtask

	// Interrupt request, usually passing, then readback
	task automatic irq_frame();
		logic [7:0] cmd;
		cmd = sb.irq_cmd;
		send_byte(8'($urandom_range(0, 255)));
		send_byte(cmd);
		send_byte(($urandom_range(0, 4) != 0) ? ~cmd : 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0)
			send_byte(8'($urandom_range(0, 255)));
		else
			send_stop();
		repeat ($urandom_range(0, 6)) send_read($urandom());
	endtask

	task automatic run_random(input int target);
		int start;
		int kind;
		start = counted;
		while (counted - start < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				if ($urandom_range(0, 1) == 0)
					send_stop();
				random_frame();
			end else if (kind < 62) begin
				if ($urandom_range(0, 1) == 0)
					send_stop();
				irq_frame();
			end else if (kind < 75) begin
				repeat ($urandom_range(1, 3)) send_read($urandom());
			end else if (kind < 85) begin
				send_stop();
			end else begin
				// noise, including the unused action code
				repeat ($urandom_range(1, 4))
					drive_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom());
			end
		end
	endtask

	task automatic run_directed();
		send_stop();
		drive_item(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		// read before any limit is set
		send_read(32'hFFFF_FFFF);
		// good frame, then its reply and a read past the limit
		send_byte(8'h00);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'hB9);
		send_read(32'h0000_0000);
		send_read(32'h0000_0000);
		// bad checksum, reply is the plain sum
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_read(32'h1234_5678);
		// interrupt request passes, readback of all four bytes and one more
		send_byte(8'h55);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_stop();
		repeat (5) send_read(32'hA5C3_0FF0);
		// interrupt request that fails, then the frame closes
		send_byte(8'hAA);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
	endtask

	initial begin
		logic [7:0] cmd_value;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_RX_BYTE;
		rx_byte = '0;
		tx_buffer_word = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle = 1'b0;
		stall_pct = 0;
		long_hold = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_command(8'h00);
		run_directed();

		// Phases over several command codes, extremes included
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: cmd_value = 8'hFF;
				1: cmd_value = 8'($urandom_range(0, 255));
				2: cmd_value = 8'h80;
				3: cmd_value = 8'h01;
				4: cmd_value = 8'($urandom_range(0, 255));
				default: cmd_value = 8'h00;
			endcase
			write_command(cmd_value);
			send_idle = (p >= 2);
			stall_pct = (p == 0) ? 0 : 25;
			// block fills up while the result side holds off
			if (p == 1)
				long_hold = 1'b1;
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("i2c_slave_command_frame_checksum verification clean");
		else
			$display("i2c_slave_command_frame_checksum verification failed");
		$finish;
	end

endmodule
